// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  `ASSERT_PROP(lbl, clk, rstn, !(prop), msg)
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif
`endif

// File: sv/gwlm_pkg.sv
// ----------------------------------------------------------------------------
// gwlm_pkg
// Widths, register indexes and shared types of the window/level gray mapper.
// ----------------------------------------------------------------------------
package gwlm_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned GRAY_W     = 8;
  localparam int unsigned LUMA_SUM_W = 13;
  localparam int unsigned WIDTH_W    = 9;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CMP_W      = 11;
  localparam int unsigned NUM_W      = 10;
  localparam int unsigned DIVISOR_W  = 10;
  localparam int unsigned PROD_W     = 18;
  localparam int unsigned QUOT_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEVEL = 2'd1;

  localparam logic [WIDTH_W-1:0] WIDTH_RST  = 9'd255;
  localparam logic [WIDTH_W-1:0] WIDTH_MIN  = 9'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_RST  = 8'd128;
  localparam logic [GRAY_W-1:0]  FULL_SCALE = 8'hFF;

  typedef struct packed {
    logic              sat_hi;
    logic [PROD_W-1:0] prod;
  } div_req_t;

  typedef struct packed {
    logic              sat_hi;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: sv/gwlm_pix_if.sv
// ----------------------------------------------------------------------------
// gwlm_pix_if
// RGB pixel request channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gwlm_pix_if;
  logic                          valid;
  logic                          ready;
  logic [gwlm_pkg::CHAN_W-1:0]   red;
  logic [gwlm_pkg::CHAN_W-1:0]   green;
  logic [gwlm_pkg::CHAN_W-1:0]   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: sv/gwlm_gray_if.sv
// ----------------------------------------------------------------------------
// gwlm_gray_if
// Mapped gray request channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gwlm_gray_if;
  logic                          valid;
  logic                          ready;
  logic [gwlm_pkg::GRAY_W-1:0]   mapped_gray;

  modport source (output valid, output mapped_gray, input ready);
  modport sink   (input valid, input mapped_gray, output ready);
endinterface

// File: sv/gray_window_level_map_unit.sv
// ----------------------------------------------------------------------------
// gray_window_level_map_unit
// RGB to luminance, then window/level mapping onto 0..255.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the pipeline can accept it and returns one
// mapped gray per pixel, in order, through one stage for luminance, one for the
// window compare, one for the x255 product and eight for the divider (one
// quotient bit each). Each stage holds its item until the next one can take
// it, so bubbles close up and a stalled output does not block input while
// any stage is free. window_width of 0 acts as 1. Write the registers only
// while no pixel is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gray_window_level_map_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  gwlm_pix_if.sink                            pix_i,
  gwlm_gray_if.source                         gray_o,
  input  logic                                cfg_we_i,
  input  logic [gwlm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gwlm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  // config
  logic [gwlm_pkg::WIDTH_W-1:0]   width_q;
  logic [gwlm_pkg::LEVEL_W-1:0]   level_q;
  logic [gwlm_pkg::WIDTH_W-1:0]   width_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= gwlm_pkg::WIDTH_RST;
      level_q <= gwlm_pkg::LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gwlm_pkg::CFG_IDX_WIDTH: width_q <= cfg_wdata_i[gwlm_pkg::WIDTH_W-1:0];
        gwlm_pkg::CFG_IDX_LEVEL: level_q <= cfg_wdata_i[gwlm_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign width_eff = (width_q == '0) ? gwlm_pkg::WIDTH_MIN : width_q;

  // stage handshake
  logic                           s0_v_q, s1_v_q, s2_v_q;
  logic                           en0, en1, en2;
  logic                           div_ready;
  logic                           div_valid;
  gwlm_pkg::div_req_t             div_req;
  gwlm_pkg::div_rsp_t             div_rsp;

  assign en2         = !s2_v_q || div_ready;
  assign en1         = !s1_v_q || en2;
  assign en0         = !s0_v_q || en1;
  assign pix_i.ready = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (en0) s0_v_q <= pix_i.valid;
      if (en1) s1_v_q <= s0_v_q;
      if (en2) s2_v_q <= s1_v_q;
    end
  end

  // stage 0: luminance
  logic [gwlm_pkg::LUMA_SUM_W-1:0] luma_sum;
  logic [gwlm_pkg::GRAY_W-1:0]     gray_q;

  assign luma_sum = gwlm_pkg::LUMA_SUM_W'(pix_i.red)   * gwlm_pkg::LUMA_SUM_W'(11)
                  + (gwlm_pkg::LUMA_SUM_W'(pix_i.green) << 4)
                  + gwlm_pkg::LUMA_SUM_W'(pix_i.blue)  * gwlm_pkg::LUMA_SUM_W'(5);

  always_ff @(posedge clk_i) begin
    if (en0) gray_q <= luma_sum[gwlm_pkg::LUMA_SUM_W-1:5];
  end

  // stage 1: window compare on doubled values
  logic [gwlm_pkg::CMP_W-1:0]     g2, lv2, w_ext, lo_sum, hi_sum, num_full;
  logic                           sat_lo, sat_hi_d;
  logic [gwlm_pkg::NUM_W-1:0]     num_d, num_q;
  logic                           sat_hi_s1_q;

  assign g2       = gwlm_pkg::CMP_W'({gray_q, 1'b0});
  assign lv2      = gwlm_pkg::CMP_W'({level_q, 1'b0});
  assign w_ext    = gwlm_pkg::CMP_W'(width_eff);
  assign lo_sum   = g2 + w_ext;
  assign hi_sum   = lv2 + w_ext;
  assign sat_lo   = (lo_sum <= lv2);
  assign sat_hi_d = (g2 >= hi_sum);
  assign num_full = lo_sum - lv2;
  assign num_d    = (sat_lo || sat_hi_d) ? '0 : num_full[gwlm_pkg::NUM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      num_q       <= num_d;
      sat_hi_s1_q <= sat_hi_d;
    end
  end

  // stage 2: numerator x255
  logic [gwlm_pkg::PROD_W-1:0]    prod_q;
  logic                           sat_hi_s2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod_q      <= {num_q, 8'b0} - gwlm_pkg::PROD_W'(num_q);
      sat_hi_s2_q <= sat_hi_s1_q;
    end
  end

  // divide by 2*width
  logic [gwlm_pkg::DIVISOR_W-1:0] divisor;

  assign divisor        = {width_eff, 1'b0};
  assign div_req.sat_hi = sat_hi_s2_q;
  assign div_req.prod   = prod_q;

  gwlm_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s2_v_q),
    .req_ready_o (div_ready),
    .req_i       (div_req),
    .divisor_i   (divisor),
    .rsp_valid_o (div_valid),
    .rsp_ready_i (gray_o.ready),
    .rsp_o       (div_rsp)
  );

  assign gray_o.valid       = div_valid;
  assign gray_o.mapped_gray = div_rsp.sat_hi ? gwlm_pkg::FULL_SCALE : div_rsp.quot;

  // checks
  `ASSERT_PROP(a_num_below_divisor, clk_i, rst_ni, (s1_v_q && !sat_hi_s1_q) |-> (num_q < divisor), "window numerator not below divisor")
  `ASSERT_NEVER(a_quot_no_full, clk_i, rst_ni, div_valid && !div_rsp.sat_hi && (div_rsp.quot == gwlm_pkg::FULL_SCALE), "unsaturated quotient reached full scale")
  `ASSERT_PROP(a_ready_when_empty_out, clk_i, rst_ni, !gray_o.valid |-> pix_i.ready, "input stalled with empty output stage")

endmodule

// File: sv/gwlm_div.sv
// ----------------------------------------------------------------------------
// gwlm_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Requires prod < divisor * 2^QUOT_W. Per-stage handshake collapses bubbles.
// ----------------------------------------------------------------------------
module gwlm_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               req_valid_i,
  output logic                               req_ready_o,
  input  gwlm_pkg::div_req_t                 req_i,
  input  logic [gwlm_pkg::DIVISOR_W-1:0]     divisor_i,
  output logic                               rsp_valid_o,
  input  logic                               rsp_ready_i,
  output gwlm_pkg::div_rsp_t                 rsp_o
);

  localparam int unsigned N = gwlm_pkg::QUOT_W;

  logic [N-1:0]                      v_q;
  logic [N:0]                        en;
  logic [gwlm_pkg::PROD_W-1:0]       rem_q  [N];
  logic [gwlm_pkg::QUOT_W-1:0]       quot_q [N];
  logic [N-1:0]                      sat_q;

  always_comb begin
    en[N] = rsp_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                          v_in;
    logic                          sat_in;
    logic [gwlm_pkg::PROD_W-1:0]   rem_in;
    logic [gwlm_pkg::QUOT_W-1:0]   quot_in;
    logic [gwlm_pkg::PROD_W-1:0]   shd;
    logic                          bit_d;
    logic [gwlm_pkg::PROD_W-1:0]   rem_d;

    if (k == 0) begin : g_first
      assign v_in    = req_valid_i;
      assign sat_in  = req_i.sat_hi;
      assign rem_in  = req_i.prod;
      assign quot_in = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign sat_in  = sat_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quot_in = quot_q[k-1];
    end

    assign shd   = gwlm_pkg::PROD_W'(divisor_i) << (N - 1 - k);
    assign bit_d = (rem_in >= shd);
    assign rem_d = bit_d ? (rem_in - shd) : rem_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k]  <= rem_d;
        quot_q[k] <= {quot_in[gwlm_pkg::QUOT_W-2:0], bit_d};
        sat_q[k]  <= sat_in;
      end
    end
  end

  assign req_ready_o   = en[0];
  assign rsp_valid_o   = v_q[N-1];
  assign rsp_o.sat_hi  = sat_q[N-1];
  assign rsp_o.quot    = quot_q[N-1];

endmodule

// File: dv/tb_gray_window_level_map_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gray_window_level_map_unit
// Self-checking bench for the window/level gray mapper.
// ----------------------------------------------------------------------------
// Pixels go in on the pixel channel. An in-bench model predicts every mapped
// gray from the luminance and the current window registers. The results are
// checked in order against that prediction. Directed tests cover the reset
// window, the window edges, zero width, register masking and the extreme
// settings. Random phases follow, each with a fresh window and mostly with
// random idle cycles per channel; one long output stall comes between them.
// ----------------------------------------------------------------------------
module tb_gray_window_level_map_unit;
  import gwlm_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 19;
  localparam int TAIL_CYCLES    = 24;
  localparam int REPORT_LIMIT   = 10;
  localparam int STALL_CYCLES   = 120;

  // unused register indexes, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t            px;
    logic [GRAY_W-1:0] gray;
  } gray_expect_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  gwlm_pix_if  pix_if ();
  gwlm_gray_if gray_if ();

  gray_window_level_map_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_if),
    .gray_o      (gray_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [WIDTH_W-1:0] win_width_m = WIDTH_RST;
  logic [LEVEL_W-1:0] win_level_m = LEVEL_RST;

  gray_expect_t gray_expect_q[$];

  bit src_gaps        = 1'b0;
  bit sink_gaps       = 1'b0;
  int hold_off_cycles = 0;
  int quiet_cycles    = 0;
  int mismatches      = 0;
  int grays_checked   = 0;
  int pixels_sent     = 0;
  int cfg_writes      = 0;
  int window_settings = 0;

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic logic [GRAY_W-1:0] window_map_gray(input pixel_t px);
    int luma;
    int w;
    int lv2;
    int g2;
    luma = (11 * int'(px.red) + 16 * int'(px.green) + 5 * int'(px.blue)) >> 5;
    w    = (win_width_m == '0) ? 1 : int'(win_width_m);
    lv2  = 2 * int'(win_level_m);
    g2   = 2 * luma;
    if (g2 <= lv2 - w) return '0;
    if (g2 >= lv2 + w) return FULL_SCALE;
    return GRAY_W'(((g2 - lv2 + w) * int'(FULL_SCALE)) / (2 * w));
  endfunction

  function automatic pixel_t gray_pixel(input int v);
    pixel_t px;
    px.red   = CHAN_W'(v);
    px.green = CHAN_W'(v);
    px.blue  = CHAN_W'(v);
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px);
    int           gap;
    gray_expect_t ent;
    gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= px.red;
    pix_if.green <= px.green;
    pix_if.blue  <= px.blue;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    ent.px   = px;
    ent.gray = window_map_gray(px);
    gray_expect_q.push_back(ent);
    pixels_sent++;
  endtask

  // stop offering and let every request in flight come out
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (gray_expect_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_IDX_WIDTH: win_width_m = data[WIDTH_W-1:0];
      CFG_IDX_LEVEL: win_level_m = data[LEVEL_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_window(input logic [CFG_DATA_W-1:0] width,
                            input logic [CFG_DATA_W-1:0] level);
    wait_idle();
    cfg_write(CFG_IDX_WIDTH, width);
    cfg_write(CFG_IDX_LEVEL, level);
    window_settings++;
  endtask

  task automatic test_reset_window();
    pixel_t px;
    send_pixel(gray_pixel(0));
    send_pixel(gray_pixel(255));
    px = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
    send_pixel(px);
    px = '{red: 8'h00, green: 8'hFF, blue: 8'h00};
    send_pixel(px);
    px = '{red: 8'h00, green: 8'h00, blue: 8'hFF};
    send_pixel(px);
  endtask

  task automatic test_window_edges();
    set_window(9'd10, 9'd100);
    send_pixel(gray_pixel(95));
    send_pixel(gray_pixel(96));
    send_pixel(gray_pixel(104));
    send_pixel(gray_pixel(105));
    // odd width puts the bounds on half steps
    set_window(9'd11, 9'd100);
    send_pixel(gray_pixel(94));
    send_pixel(gray_pixel(95));
    send_pixel(gray_pixel(105));
    send_pixel(gray_pixel(106));
  endtask

  task automatic test_zero_width();
    set_window(9'd0, 9'd100);
    send_pixel(gray_pixel(99));
    send_pixel(gray_pixel(100));
    send_pixel(gray_pixel(101));
  endtask

  task automatic test_register_masking();
    wait_idle();
    cfg_write(CFG_IDX_LEVEL, 9'h140);
    cfg_write(CFG_IDX_SPARE_A, 9'h0AA);
    cfg_write(CFG_IDX_SPARE_B, 9'h155);
    cfg_write(CFG_IDX_WIDTH, 9'd20);
    window_settings++;
    send_pixel(gray_pixel(8'h40));
    send_pixel(gray_pixel(8'h45));
  endtask

  task automatic test_window_extremes();
    set_window(9'd511, 9'd0);
    send_pixel(gray_pixel(0));
    send_pixel(gray_pixel(255));
    set_window(9'd511, 9'd255);
    send_pixel(gray_pixel(0));
    send_pixel(gray_pixel(255));
    set_window(9'd1, 9'd0);
    send_pixel(gray_pixel(0));
    send_pixel(gray_pixel(255));
    set_window(9'd1, 9'd255);
    send_pixel(gray_pixel(0));
    send_pixel(gray_pixel(255));
  endtask

  task automatic random_window();
    logic [CFG_DATA_W-1:0] width;
    logic [CFG_DATA_W-1:0] level;
    case ($urandom_range(0, 7))
      0:       width = 9'd0;
      1:       width = 9'd1;
      2:       width = 9'd511;
      3:       width = 9'($urandom_range(2, 16));
      default: width = 9'($urandom_range(1, 511));
    endcase
    case ($urandom_range(0, 5))
      0:       level = 9'h000;
      1:       level = 9'h0FF;
      default: level = 9'($urandom);
    endcase
    set_window(width, level);
    if ($urandom_range(0, 3) == 0) begin
      cfg_write($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B, 9'($urandom));
    end
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    int     w;
    int     edge2;
    int     v;
    px = pixel_t'($urandom);
    case ($urandom_range(0, 7))
      4, 5, 6: begin
        w     = (win_width_m == '0) ? 1 : int'(win_width_m);
        edge2 = $urandom_range(0, 1) ? 2 * int'(win_level_m) + w
                                     : 2 * int'(win_level_m) - w;
        v     = edge2 / 2 + $urandom_range(0, 4) - 2;
        v     = (v < 0) ? 0 : (v > 255) ? 255 : v;
        px    = gray_pixel(v);
      end
      7: begin
        px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic test_random_stream(input int phases, input int per_phase);
    repeat (phases) begin
      random_window();
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      repeat (per_phase) send_pixel(random_pixel());
    end
  endtask

  task automatic test_output_backpressure();
    random_window();
    src_gaps        = 1'b0;
    sink_gaps       = 1'b0;
    hold_off_cycles = STALL_CYCLES;
    repeat (40) send_pixel(random_pixel());
  endtask

  // result sink: random stalls plus one long hold-off on request
  initial begin : gray_sink
    int stall;
    gray_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_off_cycles > 0) begin
        gray_if.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      stall = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        gray_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      gray_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(gray_if.valid || hold_off_cycles > 0)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    gray_expect_t want;
    if (rst_ni) begin
      if ((pix_if.valid && pix_if.ready) || (gray_if.valid && gray_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (gray_if.valid && gray_if.ready) begin
        if (gray_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected gray %0d", $realtime, gray_if.mapped_gray);
          end
        end else begin
          want = gray_expect_q.pop_front();
          grays_checked++;
          if (gray_if.mapped_gray !== want.gray) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: rgb %0d/%0d/%0d w=%0d l=%0d gray exp %0d got %0d",
                       $realtime, want.px.red, want.px.green, want.px.blue,
                       win_width_m, win_level_m, want.gray, gray_if.mapped_gray);
            end
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $realtime, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_IDX_WIDTH;
    cfg_wdata_i   <= '0;
    pix_if.valid  <= 1'b0;
    pix_if.red    <= '0;
    pix_if.green  <= '0;
    pix_if.blue   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_window();
    test_window_edges();
    test_zero_width();
    test_register_masking();
    test_window_extremes();
    test_random_stream(5, 70);
    test_output_backpressure();
    test_random_stream(5, 70);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (gray_expect_q.size() != 0) mismatches++;
    $display("Sent %0d pixels, checked %0d grays over %0d window settings (%0d writes).",
             pixels_sent, grays_checked, window_settings, cfg_writes);
    $display("Included zero width, masked and spare writes, and a %0d-cycle output stall.",
             STALL_CYCLES);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
